// ----- design/clts_pkg.sv -----
// shared types and constants for the replicated log term store
package clts_pkg;
    localparam int RING_DEPTH = 1024;
    localparam int SLOT_W = $clog2(RING_DEPTH);

    localparam logic [2:0] CMD_LEADER = 3'd0;
    localparam logic [2:0] CMD_FOLLOW = 3'd1;
    localparam logic [2:0] CMD_QUERY  = 3'd2;
    localparam logic [2:0] CMD_TRUNC  = 3'd3;
    localparam logic [2:0] CMD_CONFL  = 3'd4;
    localparam logic [2:0] CMD_SNAP   = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_MISMATCH = 3'd1;
    localparam logic [2:0] ST_RANGE    = 3'd2;
    localparam logic [2:0] ST_SNAP     = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    localparam logic [2:0] ST_BAD      = 3'd5;

    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        logic [31:0]       wr_term;
        logic [31:0]       wr_data;
    } ring_req_t;

    typedef struct packed {
        logic [31:0] term;
        logic [31:0] data;
    } ring_rsp_t;
endpackage

// ----- design/clts_ring.sv -----
// term and payload ring memory with registered read
module clts_ring (
    input  logic                clk,
    input  clts_pkg::ring_req_t req,
    output clts_pkg::ring_rsp_t rsp
);
    import clts_pkg::*;

    logic [31:0] term_mem [RING_DEPTH];
    logic [31:0] data_mem [RING_DEPTH];
    logic [31:0] term_rd_reg;
    logic [31:0] data_rd_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            term_mem[req.wr_addr] <= req.wr_term;
            data_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            term_rd_reg <= term_mem[req.rd_addr];
            data_rd_reg <= data_mem[req.rd_addr];
        end
    end

    assign rsp.term = term_rd_reg;
    assign rsp.data = data_rd_reg;
endmodule

// ----- design/clts_seq.sv -----
// command sequencer: checks, ring access and conflict walk
module clts_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          command,
    input  logic [31:0]         log_index,
    input  logic [31:0]         entry_term,
    input  logic [31:0]         entry_data,
    input  logic [31:0]         prev_index,
    input  logic [31:0]         prev_term,
    input  logic                batch_first,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [167:0]        out_data,
    output clts_pkg::ring_req_t req,
    input  clts_pkg::ring_rsp_t rsp
);
    import clts_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_RD1, S_EVAL, S_RD2, S_FIN, S_WALK, S_OUT} state_t;

    state_t      state_reg, state_next;
    logic [31:0] tail_index_reg, tail_index_next, tail_term_reg, tail_term_next;
    logic [31:0] base_index_reg, base_index_next, base_term_reg, base_term_next;
    logic        batch_reg, batch_next;
    logic [2:0]  cmd_reg, cmd_next;
    logic [31:0] idx_reg, idx_next, term_reg, term_next, data_reg, data_next;
    logic [31:0] pidx_reg, pidx_next, pterm_reg, pterm_next;
    logic        first_reg, first_next;
    logic [2:0]  st_reg, st_next;
    logic [31:0] tout_reg, tout_next, dout_reg, dout_next, cidx_reg, cidx_next;
    logic [31:0] c_reg, c_next;
    logic [31:0] span;
    logic        full;

    assign span = tail_index_reg - base_index_reg;
    assign full = span >= 32'(RING_DEPTH);
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_data = {5'd0, tail_term_reg, tail_index_reg, cidx_reg, dout_reg, tout_reg,
                       st_reg};

    always_comb
    begin
        state_next = state_reg;
        tail_index_next = tail_index_reg;
        tail_term_next = tail_term_reg;
        base_index_next = base_index_reg;
        base_term_next = base_term_reg;
        batch_next = batch_reg;
        cmd_next = cmd_reg;
        idx_next = idx_reg;
        term_next = term_reg;
        data_next = data_reg;
        pidx_next = pidx_reg;
        pterm_next = pterm_reg;
        first_next = first_reg;
        st_next = st_reg;
        tout_next = tout_reg;
        dout_next = dout_reg;
        cidx_next = cidx_reg;
        c_next = c_reg;
        req = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next = command;
                    idx_next = log_index;
                    term_next = entry_term;
                    data_next = entry_data;
                    pidx_next = prev_index;
                    pterm_next = prev_term;
                    first_next = batch_first;
                    st_next = ST_OK;
                    tout_next = '0;
                    dout_next = '0;
                    cidx_next = '0;
                    state_next = S_RD1;
                end
            end
            S_RD1:
            begin
                // first read: prev entry for checks, else the addressed entry
                req.rd_en = 1'b1;
                if (cmd_reg == CMD_FOLLOW || cmd_reg == CMD_CONFL)
                    req.rd_addr = pidx_reg[SLOT_W-1:0];
                else
                    req.rd_addr = idx_reg[SLOT_W-1:0];
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = S_OUT;
                case (cmd_reg)
                    CMD_LEADER:
                    begin
                        if (idx_reg != tail_index_reg + 32'd1 || tail_index_reg == '1)
                            st_next = ST_BAD;
                        else if (full)
                            st_next = ST_FULL;
                        else
                        begin
                            req.wr_en = 1'b1;
                            req.wr_addr = idx_reg[SLOT_W-1:0];
                            req.wr_term = term_reg;
                            req.wr_data = data_reg;
                            tail_index_next = idx_reg;
                            tail_term_next = term_reg;
                        end
                    end
                    CMD_FOLLOW:
                    begin
                        if (first_reg)
                        begin
                            if (pidx_reg == 32'd0)
                                batch_next = 1'b1;
                            else if (pidx_reg == base_index_reg)
                                batch_next = (base_term_reg == pterm_reg);
                            else if (pidx_reg < base_index_reg || pidx_reg > tail_index_reg)
                                batch_next = (pterm_reg == 32'd0);
                            else
                                batch_next = (rsp.term == pterm_reg);
                        end
                        // read entry at idx and its predecessor
                        req.rd_en = 1'b1;
                        req.rd_addr = idx_reg[SLOT_W-1:0];
                        state_next = S_RD2;
                    end
                    CMD_QUERY:
                    begin
                        if (idx_reg <= base_index_reg)
                        begin
                            st_next = ST_SNAP;
                            tout_next = base_term_reg;
                        end
                        else if (idx_reg > tail_index_reg)
                            st_next = ST_RANGE;
                        else
                        begin
                            tout_next = rsp.term;
                            dout_next = rsp.data;
                        end
                    end
                    CMD_TRUNC:
                    begin
                        if (idx_reg <= base_index_reg)
                            st_next = ST_SNAP;
                        else if (idx_reg < tail_index_reg)
                        begin
                            tail_index_next = idx_reg;
                            tail_term_next = rsp.term;
                        end
                    end
                    CMD_CONFL:
                    begin
                        if (pidx_reg <= base_index_reg)
                        begin
                            st_next = ST_SNAP;
                            cidx_next = base_index_reg + 32'd1;
                        end
                        else if (pidx_reg > tail_index_reg)
                        begin
                            st_next = ST_RANGE;
                            cidx_next = tail_index_reg + 32'd1;
                        end
                        else if (rsp.term != pterm_reg)
                        begin
                            st_next = ST_MISMATCH;
                            tout_next = rsp.term;
                            c_next = pidx_reg;
                            if (pidx_reg > base_index_reg + 32'd1)
                            begin
                                req.rd_en = 1'b1;
                                req.rd_addr = SLOT_W'(pidx_reg - 32'd1);
                                state_next = S_WALK;
                            end
                            else
                                cidx_next = pidx_reg;
                        end
                    end
                    CMD_SNAP:
                    begin
                        base_index_next = idx_reg;
                        base_term_next = term_reg;
                        tail_index_next = idx_reg;
                        tail_term_next = term_reg;
                        batch_next = 1'b0;
                    end
                    default: st_next = ST_BAD;
                endcase
            end
            S_RD2:
            begin
                req.rd_en = 1'b1;
                req.rd_addr = SLOT_W'(idx_reg - 32'd1);
                state_next = S_OUT;
                if (!batch_reg)
                    st_next = ST_MISMATCH;
                else if (idx_reg <= base_index_reg)
                    st_next = ST_SNAP;
                else if (idx_reg <= tail_index_reg)
                begin
                    if (rsp.term != term_reg)
                        state_next = S_FIN;
                end
                else if (idx_reg == tail_index_reg + 32'd1 && tail_index_reg != '1)
                begin
                    if (full)
                        st_next = ST_FULL;
                    else
                    begin
                        req.wr_en = 1'b1;
                        req.wr_addr = idx_reg[SLOT_W-1:0];
                        req.wr_term = term_reg;
                        req.wr_data = data_reg;
                        tail_index_next = idx_reg;
                        tail_term_next = term_reg;
                    end
                end
                else
                    st_next = ST_BAD;
            end
            S_FIN:
            begin
                // conflict overwrite: truncate then append, fullness after truncation
                if (idx_reg - 32'd1 - base_index_reg >= 32'(RING_DEPTH))
                begin
                    st_next = ST_FULL;
                    tail_index_next = idx_reg - 32'd1;
                    if (idx_reg - 32'd1 == base_index_reg)
                        tail_term_next = base_term_reg;
                    else
                        tail_term_next = rsp.term;
                end
                else
                begin
                    req.wr_en = 1'b1;
                    req.wr_addr = idx_reg[SLOT_W-1:0];
                    req.wr_term = term_reg;
                    req.wr_data = data_reg;
                    tail_index_next = idx_reg;
                    tail_term_next = term_reg;
                end
                state_next = S_OUT;
            end
            S_WALK:
            begin
                // rsp holds term at c_reg-1
                if (rsp.term == tout_reg)
                begin
                    c_next = c_reg - 32'd1;
                    if (c_reg - 32'd1 > base_index_reg + 32'd1)
                    begin
                        req.rd_en = 1'b1;
                        req.rd_addr = SLOT_W'(c_reg - 32'd2);
                    end
                    else
                    begin
                        cidx_next = c_reg - 32'd1;
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    cidx_next = c_reg;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tail_index_reg <= '0;
            tail_term_reg <= '0;
            base_index_reg <= '0;
            base_term_reg <= '0;
            batch_reg <= 1'b0;
            cmd_reg <= '0;
            idx_reg <= '0;
            term_reg <= '0;
            data_reg <= '0;
            pidx_reg <= '0;
            pterm_reg <= '0;
            first_reg <= 1'b0;
            st_reg <= ST_OK;
            tout_reg <= '0;
            dout_reg <= '0;
            cidx_reg <= '0;
            c_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tail_index_reg <= tail_index_next;
            tail_term_reg <= tail_term_next;
            base_index_reg <= base_index_next;
            base_term_reg <= base_term_next;
            batch_reg <= batch_next;
            cmd_reg <= cmd_next;
            idx_reg <= idx_next;
            term_reg <= term_next;
            data_reg <= data_next;
            pidx_reg <= pidx_next;
            pterm_reg <= pterm_next;
            first_reg <= first_next;
            st_reg <= st_next;
            tout_reg <= tout_next;
            dout_reg <= dout_next;
            cidx_reg <= cidx_next;
            c_reg <= c_next;
        end
    end
endmodule

// ----- design/consensus_log_term_store.sv -----
// top level of the replicated log term and payload store
// usage:
//   one command per slave transfer on s_axis; one result per master transfer
//   on m_axis. s_axis_tready is high only while the block is idle.
//   states: query, truncate, leader append and snapshot pass through S_RD1
//   and S_EVAL to the result; follower append adds S_RD2 and, on a term
//   conflict, S_FIN; conflict search walks back in S_WALK entry by entry;
//   all set by the single read port of the ring memory, which is read one
//   entry a cycle. the next command can be taken in the cycle after the
//   result transfer.
//   the result waits in the output register while m_axis_tready is low and no
//   new command is taken until it is transferred.
//   reset clears tail, base, terms and the batch flag; ring contents are not
//   cleared and are only read where written.
module consensus_log_term_store (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // command[2:0], log_index[34:3], entry_term[66:35], entry_data[98:67],
    // prev_index[130:99], prev_term[162:131], zero fill to 168
    input  logic [167:0] s_axis_tdata,
    // batch_first
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[2:0], term_out[34:3], data_out[66:35], conf_index[98:67],
    // last_index[130:99], last_term[162:131], zero fill to 168
    output logic [167:0] m_axis_tdata
);
    import clts_pkg::*;

    ring_req_t req;
    ring_rsp_t rsp;

    clts_seq u_seq (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .command(s_axis_tdata[2:0]), .log_index(s_axis_tdata[34:3]),
        .entry_term(s_axis_tdata[66:35]), .entry_data(s_axis_tdata[98:67]),
        .prev_index(s_axis_tdata[130:99]), .prev_term(s_axis_tdata[162:131]),
        .batch_first(s_axis_tuser),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_data(m_axis_tdata), .req(req), .rsp(rsp)
    );

    clts_ring u_ring (.clk(clk), .req(req), .rsp(rsp));

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while result pending");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("ready right after a transfer");
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:0] <= ST_BAD))
        else $error("bad status code");
endmodule
